// File: design/pipm_pkg.sv
// shared types and constants for the pulse impedance peak meter
// used by pipm_ctrl, pipm_dp and the top level
`default_nettype none
package pipm_pkg;

  localparam int MAX_PAIRS_DEF = 512;

  localparam logic [1:0] REG_VFLOOR = 2'd0;
  localparam logic [1:0] REG_IFLOOR = 2'd1;
  localparam logic [1:0] REG_MINPAIRS = 2'd2;
  localparam logic [1:0] REG_NODATA = 2'd3;

  localparam logic [11:0] RST_VFLOOR = 12'd3;
  localparam logic [11:0] RST_IFLOOR = 12'd3;
  localparam logic [9:0] RST_MINPAIRS = 10'd10;
  localparam logic [15:0] RST_NODATA = 16'd9999;
  localparam logic [11:0] V_FULL = 12'd4095;

  typedef struct packed {
    logic [11:0] voltage_sample;
    logic [11:0] current_sample;
    logic burst_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] impedance_mean;
    logic no_data;
    logic [16:0] peak_voltage;
    logic [15:0] peak_current;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_DIV1, ST_ACC, ST_DIV2, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;     // latch item, first scaling stage
    logic scale;    // second scaling stage, start divider
    logic div_step; // one divider iteration
    logic acc;      // add quotient, update peaks
    logic mean_start;
    logic emit;     // build result, clear accumulators
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic mean_needed;
  } sts_t;

endpackage
`default_nettype wire

// File: design/pipm_ctrl.sv
// controller state machine for the pulse impedance peak meter
// depends on pipm_pkg
`default_nettype none
module pipm_ctrl import pipm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign out_valid = ov_r;
  assign in_stall = (state_r != ST_IDLE) || ov_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid && !in_stall) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIV1;
      ST_DIV1:  if (sts.div_done) state_nxt = ST_ACC;
      ST_ACC: begin
        if (!sts.last) state_nxt = ST_IDLE;
        else if (sts.mean_needed) state_nxt = ST_DIV2;
        else state_nxt = ST_OUT;
      end
      ST_DIV2:  if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid && !in_stall;
      ST_SCALE: cmd.scale = 1'b1;
      ST_DIV1:  cmd.div_step = !sts.div_done;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.mean_start = sts.last && sts.mean_needed;
      end
      ST_DIV2:  cmd.div_step = !sts.div_done;
      ST_OUT:   cmd.emit = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (cmd.emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// File: design/pipm_dp.sv
// datapath: scaling, shared restoring divider, accumulators and peaks
// depends on pipm_pkg; driven by pipm_ctrl
`default_nettype none
module pipm_dp import pipm_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire in_item_t in_item,
  input  wire cmd_t     cmd,
  output sts_t          sts,
  output out_item_t     out_item
);
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam logic [CW-1:0] MAXP = CW'(MAX_PAIRS);

  logic [11:0] vfl_r, ifl_r;
  logic [9:0]  minp_r;
  logic [15:0] nod_r;

  logic [11:0] i_r;
  logic        last_r, imp_ok_r, pk_ok_r;
  logic [22:0] num_r;      // 68*1887*v/100 fits 23 bits
  logic [16:0] pv_r;
  logic [15:0] pc_r;
  logic [24:0] t1_r;       // voltage scaling intermediate
  logic [15:0] a_r;        // scaled voltage after the divide by 53
  logic [8:0]  pcq_r;

  // shared divider: 32-bit dividend, 32-bit divisor
  logic [31:0] dq_r, drem_r, dd_r;
  logic [5:0]  dcnt_r;

  logic [31:0] sum_r;
  logic [CW-1:0] cnt_r;
  logic [16:0] vpk_r;
  logic [15:0] ipk_r;

  logic [32:0] trial;
  assign trial = {drem_r, dq_r[31]} - {1'b0, dd_r};

  logic ok_cnt;
  assign ok_cnt = (cnt_r != '0) && ({{(32-CW){1'b0}}, cnt_r} >= {22'd0, minp_r});

  // count as it stands once the current pair is accumulated
  logic [CW:0] cnt_next;
  logic        ok_next;
  assign cnt_next = {1'b0, cnt_r} + {{CW{1'b0}}, imp_ok_r};
  assign ok_next = (cnt_next != '0) && ({{(31-CW){1'b0}}, cnt_next} >= {22'd0, minp_r});

  assign sts.div_done = (dcnt_r == 6'd0);
  assign sts.last = last_r;
  assign sts.mean_needed = ok_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfl_r <= RST_VFLOOR;
      ifl_r <= RST_IFLOOR;
      minp_r <= RST_MINPAIRS;
      nod_r <= RST_NODATA;
      sum_r <= '0;
      cnt_r <= '0;
      vpk_r <= '0;
      ipk_r <= '0;
      dcnt_r <= '0;
    end else begin
      // times 1086 then divide by 1000, folded into one reciprocal constant
      pv_r <= 17'(({38'd0, a_r} * 54'd149258704044) >> 37);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VFLOOR:   vfl_r <= cfg_data[11:0];
          REG_IFLOOR:   ifl_r <= cfg_data[11:0];
          REG_MINPAIRS: minp_r <= cfg_data[9:0];
          REG_NODATA:   nod_r <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.load) begin
        i_r <= in_item.current_sample;
        last_r <= in_item.burst_end;
        imp_ok_r <= (in_item.voltage_sample > vfl_r) &&
                    (in_item.current_sample > ifl_r) && (cnt_r < MAXP);
        pk_ok_r <= (in_item.voltage_sample > vfl_r) && (in_item.voltage_sample < V_FULL);
        // 68*1887 = 100*1283 + 16, so only 16*v/100 = 4*v/25 needs a reciprocal
        num_r <= ({11'd0, in_item.voltage_sample} * 23'd1283) +
                 23'(({14'd0, in_item.voltage_sample} * 26'd10486) >> 16);
        t1_r <= 25'((({13'd0, in_item.voltage_sample} * 25'd3300) >> 12) * 1000);
        // 33000/(4095*68) = 550/4641, exact reciprocal over 12-bit current
        pcq_r <= 9'(({31'd0, in_item.current_sample} * 43'd2035968550) >> 34);
      end
      if (cmd.scale) begin
        // divide by 53 via reciprocal
        a_r <= 16'(({23'd0, t1_r} * 48'd5064820) >> 28);
        pc_r <= 16'(pcq_r * 100);
        dq_r <= {9'd0, num_r};
        drem_r <= '0;
        dd_r <= {20'd0, i_r};
        dcnt_r <= imp_ok_r ? 6'd32 : 6'd0;
      end
      if (cmd.div_step) begin
        if (!trial[32]) begin
          drem_r <= trial[31:0];
          dq_r <= {dq_r[30:0], 1'b1};
        end else begin
          drem_r <= {drem_r[30:0], dq_r[31]};
          dq_r <= {dq_r[30:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.acc) begin
        if (imp_ok_r) begin
          sum_r <= sum_r + dq_r;
          cnt_r <= cnt_r + CW'(1);
        end
        if (pk_ok_r && pv_r > vpk_r) vpk_r <= pv_r;
        if (pk_ok_r && pc_r > ipk_r) ipk_r <= pc_r;
      end
      if (cmd.mean_start) begin
        dq_r <= imp_ok_r ? sum_r + dq_r : sum_r;
        drem_r <= '0;
        dd_r <= {{(32-CW){1'b0}}, imp_ok_r ? cnt_r + CW'(1) : cnt_r};
        dcnt_r <= 6'd32;
      end
      if (cmd.emit) begin
        out_item.no_data <= !ok_cnt;
        out_item.impedance_mean <= !ok_cnt ? nod_r :
                                   (dq_r[31:16] != '0) ? 16'hFFFF : dq_r[15:0];
        out_item.peak_voltage <= vpk_r;
        out_item.peak_current <= ipk_r;
        sum_r <= '0;
        cnt_r <= '0;
        vpk_r <= '0;
        ipk_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/pulse_impedance_peak_meter.sv
// pulse impedance peak meter, top level
// each pair runs through load, scale, the divider iterations and accumulate before the next
// pair is taken; a pair that fails its floors skips the divider iterations
// after the last pair of a burst the mean division follows when enough pairs counted, then the
// result is emitted; input stalls while a pair is in progress or a result waits
// synchronous active-low reset restores register defaults and clears accumulators
`default_nettype none
module pulse_impedance_peak_meter import pipm_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  pipm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  pipm_dp #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

  // result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // no new item while a result is pending
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");
  // load, emit and acc never coincide
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.emit, cmd.acc}))
    else $error("conflicting commands");
endmodule
`default_nettype wire

// File: sim/tb_pulse_impedance_peak_meter.sv
// testbench for pulse_impedance_peak_meter: random and directed bursts with an internal predictor
// depends on pipm_pkg (item types, register indexes) and the design top level
`default_nettype none
module tb_pulse_impedance_peak_meter;
  import pipm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIR_LIMIT = MAX_PAIRS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = REG_VFLOOR;
  logic [15:0] cfg_data = '0;

  pulse_impedance_peak_meter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of registers and accumulators
  logic [11:0] vfloor_q = RST_VFLOOR;
  logic [11:0] ifloor_q = RST_IFLOOR;
  logic [9:0] minpairs_q = RST_MINPAIRS;
  logic [15:0] nodata_q = RST_NODATA;
  logic [31:0] imp_sum;
  logic [31:0] pair_cnt;
  logic [31:0] vpeak;
  logic [31:0] ipeak;

  in_item_t pending_pairs[$];
  out_item_t expected_results[$];
  int pairs_sent = 0;
  int results_seen = 0;
  int nodata_seen = 0;
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic logic [31:0] volts_mv(logic [31:0] v);
    logic [31:0] t;
    t = (v * 32'd3300) / 32'd4096;
    t = (t * 32'd1000) / 32'd53;
    return (t * 32'd1086) / 32'd1000;
  endfunction

  function automatic logic [31:0] amps_scaled(logic [31:0] i);
    return ((i * 32'd33000) / (32'd4095 * 32'd68)) * 32'd100;
  endfunction

  task automatic accumulate_pair(in_item_t p);
    logic [31:0] v, i, num, mean;
    out_item_t r;
    v = {20'd0, p.voltage_sample};
    i = {20'd0, p.current_sample};
    if (v > vfloor_q && i > ifloor_q && pair_cnt < PAIR_LIMIT) begin
      num = (32'd68 * v * 32'd1887) / 32'd100;
      imp_sum = imp_sum + num / i;
      pair_cnt = pair_cnt + 1;
    end
    if (v > vfloor_q && v < V_FULL) begin
      if (volts_mv(v) > vpeak) vpeak = volts_mv(v);
      if (amps_scaled(i) > ipeak) ipeak = amps_scaled(i);
    end
    if (p.burst_end) begin
      if (pair_cnt == 0 || pair_cnt < minpairs_q) begin
        r.impedance_mean = nodata_q;
        r.no_data = 1'b1;
      end else begin
        mean = imp_sum / pair_cnt;
        r.impedance_mean = (mean > 32'd65535) ? 16'hFFFF : mean[15:0];
        r.no_data = 1'b0;
      end
      r.peak_voltage = vpeak[16:0];
      r.peak_current = ipeak[15:0];
      expected_results.push_back(r);
      imp_sum = 0;
      pair_cnt = 0;
      vpeak = 0;
      ipeak = 0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s at result %0d: got %0d expected %0d", what, results_seen, got, want);
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        accumulate_pair(in_data);
        pairs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_data <= pending_pairs.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off, counted here
  int hold_off = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= 20) begin
        hold_done <= 1'b1;
        hold_off <= 1500;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
      end
    end
  end

  // monitor with random stalls
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected item", 32'(out_data.impedance_mean), 32'd0);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_data.impedance_mean !== e.impedance_mean)
            report("impedance_mean", 32'(out_data.impedance_mean), 32'(e.impedance_mean));
          if (out_data.no_data !== e.no_data)
            report("no_data", 32'(out_data.no_data), 32'(e.no_data));
          if (out_data.peak_voltage !== e.peak_voltage)
            report("peak_voltage", 32'(out_data.peak_voltage), 32'(e.peak_voltage));
          if (out_data.peak_current !== e.peak_current)
            report("peak_current", 32'(out_data.peak_current), 32'(e.peak_current));
          if (e.no_data) nodata_seen++;
        end
        results_seen++;
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[pulse_impedance_peak_meter] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_VFLOOR: vfloor_q = val[11:0];
      REG_IFLOOR: ifloor_q = val[11:0];
      REG_MINPAIRS: minpairs_q = val[9:0];
      default: nodata_q = val;
    endcase
  endtask

  task automatic set_regs(logic [11:0] vf, logic [11:0] cf, logic [9:0] mp, logic [15:0] nd);
    write_reg(REG_VFLOOR, {4'd0, vf});
    write_reg(REG_IFLOOR, {4'd0, cf});
    write_reg(REG_MINPAIRS, {6'd0, mp});
    write_reg(REG_NODATA, nd);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain;
    while (pending_pairs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing pair without burst end may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_pair(int v, int i, bit last);
    in_item_t p;
    p.voltage_sample = v[11:0];
    p.current_sample = i[11:0];
    p.burst_end = last;
    pending_pairs.push_back(p);
  endtask

  function automatic int pick_sample(logic [11:0] floor_v);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 4095;
      2: return (floor_v + $urandom_range(0, 2)) & 12'hFFF;
      3: return $urandom_range(0, 15);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic random_bursts(int n_pairs, int max_len);
    int len;
    while (n_pairs > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len * 3) : $urandom_range(1, max_len);
      for (int k = 0; k < len; k++)
        add_pair(pick_sample(vfloor_q), pick_sample(ifloor_q), k == len - 1);
      n_pairs -= len;
    end
  endtask

  initial begin
    imp_sum = 0; pair_cnt = 0; vpeak = 0; ipeak = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, defaults: below floor, full scale, saturating mean, too few, zero valid
    set_regs(RST_VFLOOR, RST_IFLOOR, RST_MINPAIRS, RST_NODATA);
    add_pair(0, 0, 0);
    add_pair(4094, 4095, 0);
    for (int k = 0; k < 11; k++) add_pair(4095, 4, k == 10);
    add_pair(4, 4, 1);
    add_pair(3, 3, 1);
    add_pair(4095, 4095, 1);
    drain();

    // lowest floors, zero minimum: a burst with no valid pair still gives no data
    set_regs(12'd0, 12'd0, 10'd0, 16'd0);
    add_pair(0, 0, 1);
    add_pair(1, 1, 1);
    add_pair(4095, 0, 0);
    add_pair(2048, 1, 1);
    drain();

    // highest floors, minimum at the pair limit: nothing counts
    set_regs(12'd4095, 12'd4095, 10'd512, 16'hFFFF);
    random_bursts(40, 8);
    drain();

    // burst longer than the pair limit
    set_regs(12'd3, 12'd3, 10'd512, 16'd1234);
    for (int k = 0; k < 530; k++)
      add_pair($urandom_range(4, 4094), $urandom_range(4, 4095), k == 529);
    drain();

    // random floors and small minimums, long output hold-off falls here
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
               10'($urandom_range(0, 12)), 16'($urandom_range(0, 65535)));
      random_bursts(25, 12);
      drain();
    end

    // last part without idling
    quiet = 1'b1;
    set_regs(12'd3, 12'd3, 10'd1, 16'd9999);
    random_bursts(60, 10);
    drain();

    $display("covered %0d pairs and %0d results (%0d no-data) over several register settings",
             pairs_sent, results_seen, nodata_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[pulse_impedance_peak_meter] OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("[pulse_impedance_peak_meter] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
design/pipm_pkg.sv
design/pipm_ctrl.sv
design/pipm_dp.sv
design/pulse_impedance_peak_meter.sv
sim/tb_pulse_impedance_peak_meter.sv
